FILE: sv/udmc_pkg.sv
`default_nettype none

package udmc_pkg;

  // fixed field widths
  localparam int ID_W      = 32;
  localparam int CNT_W     = 32;
  localparam int CAP_W     = 7;
  localparam int SLOT_W    = 6;
  localparam int OUT_W     = 72;
  localparam int STEP_W    = 5;

  // defaults
  localparam int              SLOTS_DEF = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // divider result seen by the lookup control
  typedef struct packed {
    logic             done;
    logic [CAP_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

FILE: sv/udmc_div.sv
`default_nettype none

// serial restoring remainder, one dividend bit per cycle
module udmc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [udmc_pkg::ID_W-1:0]    dividend,
  input  wire logic [udmc_pkg::CAP_W-1:0]   divisor,
  output udmc_pkg::div_res_t                res
);

  localparam int CW = udmc_pkg::CAP_W;
  localparam int DW = udmc_pkg::ID_W;
  localparam int SW = udmc_pkg::STEP_W;

  logic [DW-1:0] dvd_r;
  logic [CW-1:0] dsr_r;
  logic [CW-1:0] rem_r;
  logic [SW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic [CW-1:0] rem_nxt;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, dvd_r[DW-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= SW'(DW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

FILE: sv/uid_direct_mapped_cache_core.sv
// path: an accepted input beat passes through the 32-step serial remainder,
//   its done cycle, one slot read and the check before its result beat is valid
// flow: one lookup at a time, a new input beat is taken once the result is loaded
// reset: synchronous, active low; capacity returns to 64 and a clearing pass
//   empties the slot memory, no input beat is taken meanwhile
`default_nettype none

module uid_direct_mapped_cache_core #(
  parameter int SLOTS = udmc_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input beat, tdata: user_id[31:0]
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [udmc_pkg::ID_W-1:0]     in_tdata,
  // result beat, tdata: hit[0], slot_index[6:1], use_count[38:7],
  //   replaced_valid[39], replaced_id[71:40]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [udmc_pkg::OUT_W-1:0]         out_tdata,
  // capacity register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [udmc_pkg::CAP_W-1:0]    cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = udmc_pkg::CAP_W;
  localparam int IW    = udmc_pkg::ID_W;
  localparam int NW    = udmc_pkg::CNT_W;
  localparam int SLW   = udmc_pkg::SLOT_W;

  typedef struct packed {
    logic          valid;
    logic [IW-1:0] id;
    logic [NW-1:0] uses;
  } entry_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_READ, S_CHECK} state_t;

  state_t            state_r;
  logic [CW-1:0]     cap_r;
  logic [IW-1:0]     id_r;
  logic [CW-1:0]     slot_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic              out_tvalid_r;
  logic [udmc_pkg::OUT_W-1:0] out_tdata_r;

  entry_t            slot_mem [SLOTS];
  entry_t            rd_r;

  logic [CW-1:0]     eff_cap;
  logic              in_acc;
  logic              can_load;
  logic              out_load;
  udmc_pkg::div_res_t div_res;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;
  logic              mem_re;
  logic [IDX_W-1:0]  slot_idx;

  logic              hit;
  logic              rep_valid;
  logic [IW-1:0]     rep_id;
  logic [NW-1:0]     uses_nxt;

  // capacity clamped to 1..SLOTS
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (int'(cap_r) > SLOTS) begin
      eff_cap = CW'(SLOTS);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign can_load  = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_CHECK) && can_load;
  assign slot_idx  = IDX_W'(slot_r);

  udmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (in_tdata),
    .divisor  (eff_cap),
    .res      (div_res)
  );

  // hit or miss on the entry just read
  always_comb begin
    hit       = rd_r.valid && (rd_r.id == id_r);
    rep_valid = rd_r.valid && (rd_r.id != id_r);
    rep_id    = rep_valid ? rd_r.id : '0;
    uses_nxt  = hit ? (rd_r.uses + 1'b1) : NW'(1);
  end

  // memory port control: clearing pass or write back of the looked-up entry
  always_comb begin
    mem_re = (state_r == S_READ);
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we      = out_load;
      mem_wa      = slot_idx;
      mem_wd.valid = 1'b1;
      mem_wd.id    = id_r;
      mem_wd.uses  = uses_nxt;
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= slot_mem[slot_idx];
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= udmc_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  // lookup sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result valid: set on a finished lookup, cleared once taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IDX_W'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            id_r    <= in_tdata;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            slot_r  <= div_res.rem;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (can_load) begin
            out_tdata_r  <= {rep_id, rep_valid, uses_nxt, slot_r[SLW-1:0], hit};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: sv/udmc_chk.sv
`default_nettype none

module udmc_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [udmc_pkg::OUT_W-1:0]  out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a hit never reports a displaced entry
  a_hit_no_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[39])
    else $error("hit with displaced entry");

  // no displaced entry means a zero id
  a_rep_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[39] |-> out_tdata[71:40] == 32'd0)
    else $error("displaced id without displacement");

  // a miss starts the entry at one use
  a_miss_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[38:7] == 32'd1)
    else $error("miss with use count other than one");

  // one lookup at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a lookup is running");

endmodule

bind uid_direct_mapped_cache_core udmc_chk u_udmc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: verif/tb_uid_direct_mapped_cache_core.sv
`default_nettype none

module tb_uid_direct_mapped_cache_core;

  // pacing of the two stream sides
  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  // one expected lookup result
  typedef struct packed {
    logic                        hit;
    logic [udmc_pkg::SLOT_W-1:0] slot_index;
    logic [udmc_pkg::CNT_W-1:0]  use_count;
    logic                        replaced_valid;
    logic [udmc_pkg::ID_W-1:0]   replaced_id;
  } lookup_result_t;

  localparam logic [udmc_pkg::ID_W-1:0] ID_ALL_ONES = '1;
  localparam int              DRAIN_CYCLES = 60;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [udmc_pkg::ID_W-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [udmc_pkg::OUT_W-1:0] out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [udmc_pkg::CAP_W-1:0] cfg_data = '0;

  // shadow copy of the cache and its capacity register
  logic [udmc_pkg::CAP_W-1:0]     cap_shadow = udmc_pkg::CAP_RESET;
  logic [udmc_pkg::SLOTS_DEF-1:0] shadow_valid = '0;
  logic [udmc_pkg::ID_W-1:0]      shadow_id [udmc_pkg::SLOTS_DEF];
  logic [udmc_pkg::CNT_W-1:0]     shadow_uses [udmc_pkg::SLOTS_DEF];

  lookup_result_t    pending_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  uid_direct_mapped_cache_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

  // compute the lookup result and update the shadow cache
  task automatic predict_lookup(input logic [udmc_pkg::ID_W-1:0] id);
    lookup_result_t r;
    int unsigned eff_cap;
    int unsigned slot;
    eff_cap = (cap_shadow == 0) ? 1 :
              ((cap_shadow > udmc_pkg::SLOTS_DEF) ? udmc_pkg::SLOTS_DEF : int'(cap_shadow));
    slot = id % eff_cap;
    r = '0;
    r.slot_index = slot[udmc_pkg::SLOT_W-1:0];
    if (shadow_valid[slot] && shadow_id[slot] == id) begin
      shadow_uses[slot] = shadow_uses[slot] + 1;
      r.hit = 1'b1;
    end else begin
      if (shadow_valid[slot]) begin
        r.replaced_valid = 1'b1;
        r.replaced_id    = shadow_id[slot];
      end
      shadow_valid[slot] = 1'b1;
      shadow_id[slot]    = id;
      shadow_uses[slot]  = 1;
    end
    r.use_count = shadow_uses[slot];
    pending_results.push_back(r);
  endtask

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      PACE_SENDER_IDLE: begin
        sender_idle_pct = 82;
        recv_stall_pct  = 0;
      end
      PACE_RECEIVER_STALL: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 82;
      end
      default: begin
        sender_idle_pct = 16;
        recv_stall_pct  = 16;
      end
    endcase
  endtask

  // send one lookup beat; tvalid stays high for a following beat
  task automatic send_lookup(input logic [udmc_pkg::ID_W-1:0] id);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    do @(posedge clk); while (!in_tready);
    predict_lookup(id);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // capacity write, only with the cache idle
  task automatic write_capacity(input logic [udmc_pkg::CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cap_shadow = cap;
  endtask

  // id that lands in a given slot under the current capacity
  function automatic logic [udmc_pkg::ID_W-1:0] id_in_slot(input int unsigned slot);
    longint unsigned v;
    int unsigned eff_cap;
    eff_cap = (cap_shadow == 0) ? 1 :
              ((cap_shadow > udmc_pkg::SLOTS_DEF) ? udmc_pkg::SLOTS_DEF : int'(cap_shadow));
    v = longint'($urandom());
    v = v - (v % eff_cap) + (slot % eff_cap);
    if (v > 64'hFFFF_FFFF) v = v - eff_cap;
    return v[udmc_pkg::ID_W-1:0];
  endfunction

  task automatic test_reset_capacity();
    logic [udmc_pkg::ID_W-1:0] ids [12];
    ids = '{32'd0, 32'd0, 32'd0, 32'd64, ID_ALL_ONES, ID_ALL_ONES,
            32'hFFFF_FFFE, 32'd63, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1};
    set_pace(PACE_FULL);
    foreach (ids[i]) send_lookup(ids[i]);
    wait_drained();
  endtask

  // zero capacity, saturation, one slot and a change with entries kept
  task automatic test_capacity_extremes();
    set_pace(PACE_BOTH);
    write_capacity(7'd0);
    send_lookup(32'd5);
    send_lookup(32'd5);
    send_lookup(ID_ALL_ONES);
    write_capacity(7'd127);
    send_lookup(ID_ALL_ONES);
    send_lookup(32'd1);
    write_capacity(7'd1);
    send_lookup(32'd1);
    send_lookup(32'hFFFF_FFFE);
    write_capacity(7'd3);
    send_lookup(ID_ALL_ONES);
    send_lookup(32'd2);
    write_capacity(7'd64);
    send_lookup(32'd2);
    send_lookup(32'd1);
    wait_drained();
  endtask

  // pool of colliding ids for hits and replacements, plus full-range noise and ids near both ends
  task automatic test_random_lookups(input logic [udmc_pkg::CAP_W-1:0] cap,
                                     input pace_t pace, input int unsigned count);
    logic [udmc_pkg::ID_W-1:0] pool [12];
    int unsigned     hot_slot [4];
    int unsigned     pick;
    logic [udmc_pkg::ID_W-1:0] id;
    write_capacity(cap);
    set_pace(pace);
    foreach (hot_slot[i]) hot_slot[i] = $urandom_range(0, udmc_pkg::SLOTS_DEF - 1);
    foreach (pool[i]) pool[i] = id_in_slot(hot_slot[$urandom_range(0, 3)]);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        id = pool[$urandom_range(0, 11)];
      end else if (pick < 85) begin
        id = $urandom();
      end else if (pick < 93) begin
        id = ID_ALL_ONES - $urandom_range(0, 200);
      end else begin
        id = $urandom_range(0, 200);
      end
      send_lookup(id);
    end
    wait_drained();
  endtask

  // receiver pacing and result checking
  function automatic void report_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    lookup_result_t exp_r;
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, out_tdata);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        report_field("hit", exp_r.hit, out_tdata[0]);
        report_field("slot_index", exp_r.slot_index, out_tdata[6:1]);
        report_field("use_count", exp_r.use_count, out_tdata[38:7]);
        report_field("replaced_valid", exp_r.replaced_valid, out_tdata[39]);
        report_field("replaced_id", exp_r.replaced_id, out_tdata[71:40]);
      end
    end
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_capacity();
    test_capacity_extremes();
    test_random_lookups(7'd64, PACE_FULL, 200);
    test_random_lookups(7'd64, PACE_SENDER_IDLE, 200);
    test_random_lookups(7'd64, PACE_RECEIVER_STALL, 200);
    test_random_lookups(7'd64, PACE_BOTH, 200);
    test_random_lookups(7'd1, PACE_BOTH, 150);
    test_random_lookups(7'd0, PACE_FULL, 100);
    test_random_lookups(7'd127, PACE_RECEIVER_STALL, 150);
    test_random_lookups(7'd7, PACE_SENDER_IDLE, 150);
    test_random_lookups(7'($urandom_range(2, 63)), PACE_BOTH, 150);
    test_random_lookups(7'd100, PACE_FULL, 100);
    test_random_lookups(7'd64, PACE_BOTH, 100);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/udmc_pkg.sv
sv/udmc_div.sv
sv/uid_direct_mapped_cache_core.sv
sv/udmc_chk.sv
verif/tb_uid_direct_mapped_cache_core.sv
